// ----- design/qlt_pkg.sv -----
`timescale 1ns / 1ps

package qlt_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0]  token_byte;
    logic        token_byte_valid;
    logic        token_end;
    logic        line_end;
    logic        line_error;
    logic        stream_end;
    logic [15:0] line_count;
    logic [15:0] column;
  } result_t;

  localparam int unsigned OutCountBits = 16;

endpackage

// ----- design/qlt_lexer.sv -----
`timescale 1ns / 1ps

module qlt_lexer #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  qlt_pkg::item_t   item,
  output qlt_pkg::result_t result
);

  localparam logic [7:0] ChNl  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChDq  = 8'h22;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BARE   = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_QMARK  = 2'd3
  } mode_t;

  mode_t                  lex_mode, lex_mode_next;
  logic                   token_nonempty, token_nonempty_next;
  logic                   at_line_start, at_line_start_next;
  logic [LINE_BITS-1:0]   line_counter, line_counter_next;
  logic [COLUMN_BITS-1:0] column_counter, column_counter_next;
  logic [COLUMN_BITS-1:0] column_base;
  logic [LINE_BITS-1:0]   line_shown;
  logic [COLUMN_BITS-1:0] column_shown;
  logic [15:0]            line_out, column_out;

  logic [7:0] tb;
  logic       tv, tend, lend, lerr;
  logic       nl, blank, dq;

  assign nl    = (item.byte_in == ChNl);
  assign blank = (item.byte_in == ChSp) || (item.byte_in == ChTab);
  assign dq    = (item.byte_in == ChDq);

  always_comb begin
    lex_mode_next       = lex_mode;
    token_nonempty_next = token_nonempty;
    at_line_start_next  = at_line_start;
    line_counter_next   = line_counter;
    column_counter_next = column_counter;
    column_base         = column_counter;
    tb   = 8'd0;
    tv   = 1'b0;
    tend = 1'b0;
    lend = 1'b0;
    lerr = 1'b0;
    if (item.end_of_stream) begin
      tend = (lex_mode == MODE_BARE) || (lex_mode == MODE_QMARK) ||
             ((lex_mode == MODE_QUOTED) && token_nonempty);
      lend = !at_line_start;
      lex_mode_next       = MODE_IDLE;
      token_nonempty_next = 1'b0;
      at_line_start_next  = 1'b1;
    end else begin
      // a byte after a line start opens the next line
      if (at_line_start) begin
        if (line_counter != {LINE_BITS{1'b1}}) begin
          line_counter_next = line_counter + LINE_BITS'(1);
        end
        column_base        = '0;
        at_line_start_next = 1'b0;
      end
      column_counter_next = column_base;
      if (column_base != {COLUMN_BITS{1'b1}}) begin
        column_counter_next = column_base + COLUMN_BITS'(1);
      end
      unique case (lex_mode)
        MODE_IDLE: begin
          if (nl) begin
            lend = 1'b1;
          end else if (blank) begin
            lend = 1'b0;
          end else if (dq) begin
            lex_mode_next       = MODE_QUOTED;
            token_nonempty_next = 1'b0;
          end else begin
            lex_mode_next       = MODE_BARE;
            tb                  = item.byte_in;
            tv                  = 1'b1;
            token_nonempty_next = 1'b1;
          end
        end
        MODE_BARE: begin
          if (blank || nl) begin
            tend                = 1'b1;
            lend                = nl;
            lex_mode_next       = MODE_IDLE;
            token_nonempty_next = 1'b0;
          end else if (dq) begin
            lerr = 1'b1;
          end else begin
            tb = item.byte_in;
            tv = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (dq) begin
            lex_mode_next = MODE_QMARK;
          end else if (nl) begin
            lerr = 1'b1;
          end else begin
            tb                  = item.byte_in;
            tv                  = 1'b1;
            token_nonempty_next = 1'b1;
          end
        end
        MODE_QMARK: begin
          // doubled quote stands for one quote
          if (dq) begin
            lex_mode_next       = MODE_QUOTED;
            tb                  = item.byte_in;
            tv                  = 1'b1;
            token_nonempty_next = 1'b1;
          end else if (blank || nl) begin
            tend                = 1'b1;
            lend                = nl;
            lex_mode_next       = MODE_IDLE;
            token_nonempty_next = 1'b0;
          end else begin
            lerr = 1'b1;
          end
        end
        default: begin
          lerr = 1'b0;
        end
      endcase
      if (lerr || lend) begin
        lex_mode_next       = MODE_IDLE;
        token_nonempty_next = 1'b0;
        at_line_start_next  = 1'b1;
      end
    end
  end

  assign line_shown   = line_counter_next;
  assign column_shown = column_counter_next;

  // clamp wide counters to the 16-bit result fields
  if (LINE_BITS > qlt_pkg::OutCountBits) begin : g_line_clamp
    assign line_out = (|line_shown[LINE_BITS-1:qlt_pkg::OutCountBits]) ? 16'hFFFF
                    : line_shown[qlt_pkg::OutCountBits-1:0];
  end else begin : g_line_ext
    assign line_out = 16'(line_shown);
  end

  if (COLUMN_BITS > qlt_pkg::OutCountBits) begin : g_col_clamp
    assign column_out = (|column_shown[COLUMN_BITS-1:qlt_pkg::OutCountBits]) ? 16'hFFFF
                      : column_shown[qlt_pkg::OutCountBits-1:0];
  end else begin : g_col_ext
    assign column_out = 16'(column_shown);
  end

  always_comb begin
    result.token_byte       = tb;
    result.token_byte_valid = tv;
    result.token_end        = tend;
    result.line_end         = lend;
    result.line_error       = lerr;
    result.stream_end       = item.end_of_stream;
    result.line_count       = line_out;
    result.column           = column_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= MODE_IDLE;
      token_nonempty <= 1'b0;
      at_line_start  <= 1'b1;
      line_counter   <= '0;
      column_counter <= '0;
    end else if (accept) begin
      lex_mode       <= lex_mode_next;
      token_nonempty <= token_nonempty_next;
      at_line_start  <= at_line_start_next;
      line_counter   <= line_counter_next;
      column_counter <= column_counter_next;
    end
  end

endmodule

// ----- design/qlt_skid.sv -----
`timescale 1ns / 1ps

module qlt_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qlt_pkg::result_t push_data,
  output logic             full,
  output logic             result_valid,
  input  logic             result_stall,
  output qlt_pkg::result_t result
);

  logic             skid_valid;
  qlt_pkg::result_t skid_data;
  logic             out_free;

  assign full     = skid_valid;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      // output held, park the new request
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        result <= skid_data;
      end else if (push) begin
        result <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- design/quoted_line_tokenizer.sv -----
`timescale 1ns / 1ps
// a result is registered in the output register, or parked in the skid entry while the output is held
// throughput: one byte per cycle while item_stall is low; a skid entry lets a byte in while a result waits
// item_stall rises only when the output and the skid entry are both held
// reset (rst, synchronous): lexer between tokens at a line start, counters zero,
// output and skid entry empty

module quoted_line_tokenizer #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  qlt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output qlt_pkg::result_t result
);

  logic             accept;
  qlt_pkg::result_t lex_result;

  assign accept = item_valid && !item_stall;

  qlt_lexer #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_lexer (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .result(lex_result)
  );

  qlt_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_data   (lex_result),
    .full        (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// ----- design/qlt_checker.sv -----
`timescale 1ns / 1ps

module qlt_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input qlt_pkg::result_t result
);

  // a held result must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("buffers not empty after reset");

  a_byte_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.token_byte_valid |->
      !result.token_end && !result.line_end && !result.line_error && !result.stream_end)
    else $error("token byte with an end or error flag");

  a_end_err: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.line_end && result.line_error) &&
      !(result.stream_end && result.line_error))
    else $error("line end and error together");

  a_stall_after_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && result_valid && result_stall |=> item_stall)
    else $error("skid entry not taken while output held");

endmodule

bind quoted_line_tokenizer qlt_checker u_qlt_checker (.*);

// ----- verif/quoted_line_tokenizer_test.sv -----
`timescale 1ns / 1ps

module quoted_line_tokenizer_test;

  localparam int unsigned LineBits   = 16;
  localparam int unsigned ColumnBits = 16;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseItems = 155;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DQ  = 8'h22;

  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_BARE,
    LEX_QUOTED,
    LEX_QMARK
  } lex_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_stall;
  qlt_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  qlt_pkg::result_t result;

  qlt_pkg::item_t   byte_stream[$];
  qlt_pkg::result_t predicted_results[$];
  qlt_pkg::result_t want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // tokenizer state mirrored from the block
  lex_mode_t             lex_state = LEX_IDLE;
  logic                  tok_has_byte = 1'b0;
  logic                  line_pending = 1'b1;
  logic [LineBits-1:0]   line_num = '0;
  logic [ColumnBits-1:0] col_num = '0;

  quoted_line_tokenizer #(
    .LINE_BITS  (LineBits),
    .COLUMN_BITS(ColumnBits)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #6 clk = ~clk;

  function automatic qlt_pkg::result_t tokenize_byte(qlt_pkg::item_t it);
    qlt_pkg::result_t r;
    logic             nl;
    logic             blank;
    logic             dq;
    r = '0;
    nl    = (it.byte_in == CH_NL);
    blank = (it.byte_in == CH_SP) || (it.byte_in == CH_TAB);
    dq    = (it.byte_in == CH_DQ);
    if (it.end_of_stream) begin
      r.token_end = (lex_state == LEX_BARE) || (lex_state == LEX_QMARK) ||
                    (lex_state == LEX_QUOTED && tok_has_byte);
      r.line_end   = !line_pending;
      r.stream_end = 1'b1;
      r.line_count = line_num;
      r.column     = col_num;
      lex_state    = LEX_IDLE;
      tok_has_byte = 1'b0;
      line_pending = 1'b1;
    end else begin
      if (line_pending) begin
        if (line_num != '1) line_num = line_num + LineBits'(1);
        col_num = '0;
        line_pending = 1'b0;
      end
      if (col_num != '1) col_num = col_num + ColumnBits'(1);
      case (lex_state)
        LEX_IDLE: begin
          if (nl) begin
            r.line_end = 1'b1;
          end else if (dq) begin
            lex_state = LEX_QUOTED;
            tok_has_byte = 1'b0;
          end else if (!blank) begin
            lex_state = LEX_BARE;
            r.token_byte = it.byte_in;
            r.token_byte_valid = 1'b1;
            tok_has_byte = 1'b1;
          end
        end
        LEX_BARE: begin
          if (blank || nl) begin
            r.token_end = 1'b1;
            r.line_end = nl;
            lex_state = LEX_IDLE;
            tok_has_byte = 1'b0;
          end else if (dq) begin
            r.line_error = 1'b1;
          end else begin
            r.token_byte = it.byte_in;
            r.token_byte_valid = 1'b1;
          end
        end
        LEX_QUOTED: begin
          if (dq) begin
            lex_state = LEX_QMARK;
          end else if (nl) begin
            r.line_error = 1'b1;
          end else begin
            r.token_byte = it.byte_in;
            r.token_byte_valid = 1'b1;
            tok_has_byte = 1'b1;
          end
        end
        default: begin
          // a second quote is a literal quote, a blank or newline closes
          if (dq) begin
            lex_state = LEX_QUOTED;
            r.token_byte = it.byte_in;
            r.token_byte_valid = 1'b1;
            tok_has_byte = 1'b1;
          end else if (blank || nl) begin
            r.token_end = 1'b1;
            r.line_end = nl;
            lex_state = LEX_IDLE;
            tok_has_byte = 1'b0;
          end else begin
            r.line_error = 1'b1;
          end
        end
      endcase
      r.line_count = line_num;
      r.column = col_num;
      if (r.line_error || r.line_end) begin
        lex_state = LEX_IDLE;
        tok_has_byte = 1'b0;
        line_pending = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic string fmt_result(qlt_pkg::result_t r);
    return $sformatf("byte=%02h bv=%0b tend=%0b lend=%0b err=%0b send=%0b line=%0d col=%0d",
                     r.token_byte, r.token_byte_valid, r.token_end, r.line_end,
                     r.line_error, r.stream_end, r.line_count, r.column);
  endfunction

  // any byte that is not newline, blank or quote
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_NL || b == CH_SP || b == CH_TAB || b == CH_DQ) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic push_byte(logic [7:0] b);
    qlt_pkg::item_t it;
    it.byte_in = b;
    it.end_of_stream = 1'b0;
    byte_stream.insert(byte_stream.size(), it);
    items_queued++;
  endtask

  task automatic push_eos();
    qlt_pkg::item_t it;
    it.byte_in = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    byte_stream.insert(byte_stream.size(), it);
    items_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_blanks();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) push_byte($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  task automatic push_bare_token();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) push_byte(plain_byte());
  endtask

  task automatic push_quoted_token();
    int         n;
    logic [7:0] b;
    n = $urandom_range(0, 5);
    push_byte(CH_DQ);
    repeat (n) begin
      if ($urandom_range(5) == 0) begin
        push_byte(CH_DQ);
        push_byte(CH_DQ);
      end else begin
        b = 8'($urandom_range(255));
        while (b == CH_NL || b == CH_DQ) b = 8'($urandom_range(255));
        push_byte(b);
      end
    end
    push_byte(CH_DQ);
  endtask

  task automatic push_line();
    int ntok;
    ntok = $urandom_range(0, 4);
    if ($urandom_range(3) == 0) push_blanks();
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) push_blanks();
      if ($urandom_range(1)) push_bare_token();
      else push_quoted_token();
    end
    if ($urandom_range(3) == 0) push_blanks();
    if ($urandom_range(15) == 0) push_eos();
    else push_byte(CH_NL);
  endtask

  // lines that go wrong partway, followed by whatever comes next
  task automatic push_broken_line();
    if ($urandom_range(1)) push_bare_token();
    if ($urandom_range(1)) push_blanks();
    case ($urandom_range(2))
      0: begin
        push_bare_token();
        push_byte(CH_DQ);
      end
      1: begin
        push_quoted_token();
        push_byte(plain_byte());
      end
      default: begin
        push_byte(CH_DQ);
        if ($urandom_range(1)) push_byte(plain_byte());
        push_byte(CH_NL);
      end
    endcase
    if ($urandom_range(1)) push_bare_token();
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(5))
        0: push_byte(CH_DQ);
        1: push_byte(CH_NL);
        2: push_byte($urandom_range(1) ? CH_SP : CH_TAB);
        default: push_byte(8'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(5) == 0) push_eos();
  endtask

  task automatic push_random_text(int unsigned count);
    int unsigned start;
    int unsigned pick;
    start = items_queued;
    while (items_queued - start < count) begin
      pick = $urandom_range(99);
      if (pick < 70) push_line();
      else if (pick < 85) push_broken_line();
      else push_noise();
    end
  endtask

  task automatic drain();
    while (byte_stream.size() != 0 || item_valid || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        predicted_results.insert(predicted_results.size(), tokenize_byte(item));
      if (!item_valid || !item_stall) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= byte_stream.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected result: %s", fmt_result(result));
        end else begin
          want = predicted_results.pop_front();
          if (result.token_byte !== want.token_byte ||
              result.token_byte_valid !== want.token_byte_valid ||
              result.token_end !== want.token_end ||
              result.line_end !== want.line_end ||
              result.line_error !== want.line_error ||
              result.stream_end !== want.stream_end ||
              result.line_count !== want.line_count ||
              result.column !== want.column) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("mismatch expected: %s", fmt_result(want));
              $display("         actual:   %s", fmt_result(result));
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no idling: directed cases, then random text
    push_eos();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\t\" \" \"\"\n");
    push_text("\"\"\"\"");
    push_eos();
    push_text("a\"");
    push_text("\"\"y");
    push_text("\"\n");
    push_byte(CH_DQ);
    push_eos();
    push_text("\"z");
    push_eos();
    push_random_text(PhaseItems);
    drain();

    @(negedge clk);
    send_idle_pct = 64;
    recv_stall_pct = 0;
    push_random_text(PhaseItems);
    drain();

    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    push_random_text(PhaseItems);
    drain();

    @(negedge clk);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    push_random_text(PhaseItems);
    drain();

    repeat (4) @(posedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
